// ===== src/rhp_pkg.sv =====
// ----------------------------------------------------------------------------
// rhp_pkg: shared types and constants for the RTSP request head parser
// Parser phases, result codes, character kinds and byte class functions.
// ----------------------------------------------------------------------------
package rhp_pkg;

  typedef enum logic [4:0] {
    PH_METHOD_START = 5'd0,
    PH_METHOD       = 5'd1,
    PH_URI          = 5'd2,
    PH_R            = 5'd3,
    PH_T            = 5'd4,
    PH_S            = 5'd5,
    PH_P            = 5'd6,
    PH_SLASH        = 5'd7,
    PH_VMAJOR       = 5'd8,
    PH_VDOT         = 5'd9,
    PH_VMINOR       = 5'd10,
    PH_NL1          = 5'd11,
    PH_HSTART       = 5'd12,
    PH_HNAME        = 5'd13,
    PH_HSPACE       = 5'd14,
    PH_HVALUE       = 5'd15,
    PH_HVNL         = 5'd16,
    PH_EOH          = 5'd17
  } phase_t;

  typedef enum logic [2:0] {
    ST_GOING       = 3'd0,
    ST_GOOD        = 3'd1,
    ST_BAD_METHOD  = 3'd2,
    ST_BAD_URI     = 3'd3,
    ST_BAD_PROTO   = 3'd4,
    ST_BAD_VERSION = 3'd5,
    ST_BAD_HEADER  = 3'd6,
    ST_BAD_END     = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_METHOD = 3'd1,
    KIND_URI    = 3'd2,
    KIND_HNAME  = 3'd3,
    KIND_HVALUE = 3'd4
  } kind_t;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_CTL_MAX = 8'd31;

  // Control characters: 0..31 and DEL
  function automatic logic is_ctl(input logic [7:0] c);
    return (c <= CH_CTL_MAX) || (c == CH_DEL);
  endfunction

  // Separator set of the request grammar
  function automatic logic is_sep(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
      8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20, 8'h09: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Token characters: 7-bit, not control, not separator
  function automatic logic is_token(input logic [7:0] c);
    return !c[7] && !is_ctl(c) && !is_sep(c);
  endfunction

  // Expected byte of each phase of the protocol literal
  function automatic logic [7:0] lit_char(input phase_t ph);
    logic [7:0] r;
    case (ph)
      PH_R:      r = CH_R;
      PH_T:      r = CH_T;
      PH_S:      r = CH_S;
      PH_P:      r = CH_P;
      PH_SLASH:  r = CH_SLASH;
      PH_VMAJOR: r = CH_ONE;
      PH_VDOT:   r = CH_DOT;
      default:   r = CH_ZERO;
    endcase
    return r;
  endfunction

endpackage

// ===== src/rtsp_request_head_parser.sv =====
// A byte is held in the input register and its result goes to the result register.
// Throughput: one byte per cycle while the receiver does not stall; the phase
// decode sits in one stage between the input register and the result register,
// and the result register is loaded whenever it is empty or being taken.
// Reset (synchronous): phase to method start, prior byte to zero, both
// valid flags cleared.
// ----------------------------------------------------------------------------
// rtsp_request_head_parser: byte-serial RTSP request head parser
// Tags each byte as method, URI, header name or header value character and
// reports parse status per byte.
// ----------------------------------------------------------------------------
module rtsp_request_head_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [2:0] char_kind,
  output logic [7:0] char_out,
  output logic       new_header
);
  import rhp_pkg::*;

  logic       in_full;
  logic [7:0] byte_r;
  logic       advance;
  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] prior_byte;
  status_t    st_c;
  kind_t      kind_c;
  logic       newh_c;
  logic       crlf;
  logic       is_lit;

  // Move the held beat into the result register when it is free
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign crlf     = (byte_r == CH_CR) || (byte_r == CH_LF);
  assign is_lit   = (phase >= PH_R) && (phase <= PH_VMINOR);

  // Hold the input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      byte_r <= in_byte;
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_METHOD_START: begin
        if (is_token(byte_r)) phase_next = PH_METHOD;
      end
      PH_METHOD: begin
        if (byte_r == CH_SPACE) phase_next = PH_URI;
      end
      PH_URI: begin
        if (byte_r == CH_SPACE) phase_next = PH_R;
      end
      PH_R, PH_T, PH_S, PH_P, PH_SLASH, PH_VMAJOR, PH_VDOT, PH_VMINOR: begin
        if (byte_r == lit_char(phase)) phase_next = phase_t'(phase + 5'd1);
      end
      PH_NL1, PH_HSTART, PH_HVNL: begin
        if (phase == PH_HVNL && crlf) begin
          phase_next = phase;
        end else if (phase != PH_HSTART && byte_r == CH_LF) begin
          phase_next = PH_HSTART;
        end else if (phase != PH_HSTART && byte_r == CH_CR) begin
          phase_next = PH_NL1;
        end else if (crlf) begin
          phase_next = PH_EOH;
        end else if (is_token(byte_r)) begin
          phase_next = PH_HNAME;
        end else begin
          phase_next = PH_HSTART;
        end
      end
      PH_HNAME: begin
        if (byte_r == CH_COLON) phase_next = PH_HSPACE;
      end
      PH_HSPACE, PH_HVALUE: begin
        if (phase == PH_HSPACE && byte_r == CH_SPACE) begin
          phase_next = phase;
        end else if (crlf) begin
          phase_next = PH_HVNL;
        end else begin
          phase_next = PH_HVALUE;
        end
      end
      default: phase_next = phase;
    endcase
  end

  // Result of the held byte
  always_comb begin
    st_c   = ST_GOING;
    kind_c = KIND_NONE;
    newh_c = 1'b0;
    unique case (phase)
      PH_METHOD_START: begin
        if (!is_token(byte_r)) st_c = ST_BAD_METHOD;
        else kind_c = KIND_METHOD;
      end
      PH_METHOD: begin
        if (byte_r == CH_SPACE) st_c = ST_GOING;
        else if (!is_token(byte_r)) st_c = ST_BAD_METHOD;
        else kind_c = KIND_METHOD;
      end
      PH_URI: begin
        if (byte_r == CH_SPACE) st_c = ST_GOING;
        else if (is_ctl(byte_r)) st_c = ST_BAD_URI;
        else kind_c = KIND_URI;
      end
      PH_R, PH_T, PH_S, PH_P, PH_SLASH: begin
        if (byte_r != lit_char(phase)) st_c = ST_BAD_PROTO;
      end
      PH_VMAJOR, PH_VDOT, PH_VMINOR: begin
        if (byte_r != lit_char(phase)) st_c = ST_BAD_VERSION;
      end
      PH_NL1, PH_HSTART, PH_HVNL: begin
        if (phase == PH_HVNL && crlf) begin
          if (byte_r == prior_byte) st_c = ST_GOOD;
        end else if (phase != PH_HSTART && byte_r == CH_LF) begin
          st_c = ST_GOING;
        end else if (phase != PH_HSTART && byte_r == CH_CR) begin
          if (prior_byte == CH_CR) st_c = ST_GOOD;
        end else if (crlf) begin
          st_c = ST_GOING;
        end else if (!is_token(byte_r)) begin
          st_c = ST_BAD_HEADER;
        end else begin
          kind_c = KIND_HNAME;
          newh_c = 1'b1;
        end
      end
      PH_HNAME: begin
        if (byte_r == CH_COLON) st_c = ST_GOING;
        else if (!is_token(byte_r)) st_c = ST_BAD_HEADER;
        else kind_c = KIND_HNAME;
      end
      PH_HSPACE, PH_HVALUE: begin
        if (phase == PH_HSPACE && byte_r == CH_SPACE) st_c = ST_GOING;
        else if (crlf) st_c = ST_GOING;
        else if (is_ctl(byte_r)) st_c = ST_BAD_HEADER;
        else kind_c = KIND_HVALUE;
      end
      PH_EOH: begin
        if (byte_r == CH_CR) st_c = ST_GOING;
        else if (byte_r == CH_LF) st_c = ST_GOOD;
        else st_c = ST_BAD_END;
      end
      default: st_c = ST_GOING;
    endcase
  end

  // Advance parser state and load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_METHOD_START;
      prior_byte <= 8'd0;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        phase      <= phase_next;
        prior_byte <= byte_r;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid  <= 1'b0;
      end
    end
    if (advance) begin
      status     <= st_c;
      char_kind  <= kind_c;
      char_out   <= (kind_c != KIND_NONE) ? byte_r : 8'd0;
      new_header <= newh_c;
    end
  end

  // Checks
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (char_kind == KIND_NONE) |-> char_out == 8'd0)
    else $error("char_out set without a character kind");

  a_newh_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_header |-> char_kind == KIND_HNAME)
    else $error("new header flag on a non header-name byte");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(phase) && $stable(prior_byte))
    else $error("parser state moved without a beat");

  a_prior_track: assert property (@(posedge clk) disable iff (rst)
    advance |=> prior_byte == $past(byte_r))
    else $error("prior byte not the last parsed byte");

  a_lit_no_char: assert property (@(posedge clk) disable iff (rst)
    advance && is_lit |=> char_kind == KIND_NONE)
    else $error("protocol literal byte tagged as a character");

endmodule

// ===== verif/rtsp_request_head_parser_tb.sv =====
// ----------------------------------------------------------------------------
// rtsp_request_head_parser_tb: self-checking bench for the RTSP head parser
// Streams a request line with injected faults, then many random header lines
// and a final end-of-head tail, and checks every result beat against an
// in-bench parse model. Both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module rtsp_request_head_parser_tb;
  import rhp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_END    = 930;
  localparam int PAUSE_AT    = 450;
  localparam int CALM_TAIL   = 60;
  localparam int LONG_HOLD   = 80;
  localparam int HOLD_AT     = 300;
  localparam int SETTLE      = 8;
  localparam logic [8:0] PAUSE_MARK = 9'h100;

  // Parser context and the tag of one byte
  typedef struct packed {
    phase_t     phase;
    logic [7:0] prior;
  } parse_ctx_t;

  typedef struct packed {
    status_t    status;
    kind_t      kind;
    logic [7:0] ch;
    logic       newh;
  } byte_tag_t;

  typedef struct packed {
    parse_ctx_t ctx;
    byte_tag_t  tag;
  } tag_step_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] status;
  logic [2:0] char_kind;
  logic [7:0] char_out;
  logic       new_header;

  logic [8:0] feed_q[$];
  byte_tag_t  tag_fifo[$];
  parse_ctx_t gen_ctx = '{PH_METHOD_START, 8'h00};
  parse_ctx_t dut_ctx = '{PH_METHOD_START, 8'h00};
  bit         allow_eoh = 1'b0;
  bit         draining = 1'b0;
  bit         long_hold_done = 1'b0;
  int         send_gap = 0;
  int         stall_left = 0;
  int         long_hold = 0;
  int         send_idle_pct = 10;
  int         recv_idle_pct = 10;
  int         results_seen = 0;
  int         errors = 0;
  int         cycles = 0;

  rtsp_request_head_parser dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .char_kind  (char_kind),
    .char_out   (char_out),
    .new_header (new_header)
  );

  // Byte classes of the request grammar
  function automatic logic ctl_char(input logic [7:0] c);
    return (c <= CH_CTL_MAX) || (c == CH_DEL);
  endfunction

  function automatic logic sep_char(input logic [7:0] c);
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=",
      "{", "}", " ", "\t": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic token_char(input logic [7:0] c);
    return (c < 8'd128) && !ctl_char(c) && !sep_char(c);
  endfunction

  // Tag one byte and advance the parse context
  function automatic tag_step_t tag_byte(input parse_ctx_t cx, input logic [7:0] c);
    tag_step_t s;
    logic      crlf;
    s.ctx = cx;
    s.tag.status = ST_GOING;
    s.tag.kind = KIND_NONE;
    s.tag.ch = 8'h00;
    s.tag.newh = 1'b0;
    crlf = (c == CH_CR) || (c == CH_LF);
    case (cx.phase)
      PH_METHOD_START: begin
        if (!token_char(c)) s.tag.status = ST_BAD_METHOD;
        else begin
          s.ctx.phase = PH_METHOD;
          s.tag.kind = KIND_METHOD;
        end
      end
      PH_METHOD: begin
        if (c == CH_SPACE) s.ctx.phase = PH_URI;
        else if (!token_char(c)) s.tag.status = ST_BAD_METHOD;
        else s.tag.kind = KIND_METHOD;
      end
      PH_URI: begin
        if (c == CH_SPACE) s.ctx.phase = PH_R;
        else if (ctl_char(c)) s.tag.status = ST_BAD_URI;
        else s.tag.kind = KIND_URI;
      end
      PH_R:      if (c == CH_R) s.ctx.phase = PH_T; else s.tag.status = ST_BAD_PROTO;
      PH_T:      if (c == CH_T) s.ctx.phase = PH_S; else s.tag.status = ST_BAD_PROTO;
      PH_S:      if (c == CH_S) s.ctx.phase = PH_P; else s.tag.status = ST_BAD_PROTO;
      PH_P:      if (c == CH_P) s.ctx.phase = PH_SLASH; else s.tag.status = ST_BAD_PROTO;
      PH_SLASH:  if (c == CH_SLASH) s.ctx.phase = PH_VMAJOR; else s.tag.status = ST_BAD_PROTO;
      PH_VMAJOR: if (c == CH_ONE) s.ctx.phase = PH_VDOT; else s.tag.status = ST_BAD_VERSION;
      PH_VDOT:   if (c == CH_DOT) s.ctx.phase = PH_VMINOR; else s.tag.status = ST_BAD_VERSION;
      PH_VMINOR: if (c == CH_ZERO) s.ctx.phase = PH_NL1; else s.tag.status = ST_BAD_VERSION;
      PH_NL1, PH_HVNL, PH_HSTART: begin
        if (cx.phase == PH_HVNL && crlf) begin
          // repeated line-end byte closes the head, otherwise keep waiting
          if (c == cx.prior) s.tag.status = ST_GOOD;
        end else if (cx.phase != PH_HSTART && c == CH_LF) begin
          s.ctx.phase = PH_HSTART;
        end else if (cx.phase != PH_HSTART && c == CH_CR) begin
          if (cx.prior == CH_CR) s.tag.status = ST_GOOD;
          else s.ctx.phase = PH_NL1;
        end else begin
          // handle as the first byte of a header line
          s.ctx.phase = PH_HSTART;
          if (crlf) s.ctx.phase = PH_EOH;
          else if (!token_char(c)) s.tag.status = ST_BAD_HEADER;
          else begin
            s.ctx.phase = PH_HNAME;
            s.tag.kind = KIND_HNAME;
            s.tag.newh = 1'b1;
          end
        end
      end
      PH_HNAME: begin
        if (c == CH_COLON) s.ctx.phase = PH_HSPACE;
        else if (!token_char(c)) s.tag.status = ST_BAD_HEADER;
        else s.tag.kind = KIND_HNAME;
      end
      PH_HSPACE, PH_HVALUE: begin
        if (!(cx.phase == PH_HSPACE && c == CH_SPACE)) begin
          s.ctx.phase = PH_HVALUE;
          if (crlf) s.ctx.phase = PH_HVNL;
          else if (ctl_char(c)) s.tag.status = ST_BAD_HEADER;
          else s.tag.kind = KIND_HVALUE;
        end
      end
      PH_EOH: begin
        if (c != CH_CR) s.tag.status = (c == CH_LF) ? ST_GOOD : ST_BAD_END;
      end
      default: ;
    endcase
    if (s.tag.kind != KIND_NONE) s.tag.ch = c;
    s.ctx.prior = c;
    return s;
  endfunction

  function automatic logic [7:0] rand_token();
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    while (!token_char(c)) c = 8'($urandom_range(33, 126));
    return c;
  endfunction

  function automatic logic [7:0] value_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 8'($urandom_range(32, 126));
    else if (r < 9) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  // Queue a byte; keep the stream out of the end-of-head phase until the tail
  task automatic push_byte(input logic [7:0] c);
    tag_step_t trial;
    trial = tag_byte(gen_ctx, c);
    if (!allow_eoh && trial.ctx.phase == PH_EOH) begin
      c = "a";
      trial = tag_byte(gen_ctx, c);
    end
    gen_ctx = trial.ctx;
    feed_q.insert(feed_q.size(), {1'b0, c});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 4;
      default: return 25;
    endcase
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Drive input beats from the feed queue and predict their tags
  always @(posedge clk) begin : drive_beats
    logic [8:0] item;
    logic       nxt_valid;
    tag_step_t  step;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        step = tag_byte(dut_ctx, in_byte);
        dut_ctx = step.ctx;
        tag_fifo.insert(tag_fifo.size(), step.tag);
      end
      // hold a stalled beat, otherwise pick the next one
      if (!(in_valid && in_stall)) begin
        nxt_valid = 1'b0;
        if (draining) begin
          if (tag_fifo.size() == 0) draining = 1'b0;
        end else if (send_gap > 0) begin
          send_gap--;
        end else if (feed_q.size() > 0) begin
          if (feed_q.size() >= CALM_TAIL && $urandom_range(0, 99) < send_idle_pct) begin
            send_gap = $urandom_range(0, 15);
          end else begin
            item = feed_q.pop_front();
            if ($urandom_range(0, 63) == 0) send_idle_pct = pick_idle_pct();
            if (item == PAUSE_MARK) draining = 1'b1;
            else begin
              nxt_valid = 1'b1;
              in_byte <= item[7:0];
            end
          end
        end
        in_valid <= nxt_valid;
      end
    end
  end

  // Check result beats and drive the receiver stall
  always @(posedge clk) begin : take_results
    byte_tag_t want;
    byte_tag_t got;
    logic      nxt_stall;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        got = byte_tag_t'({status, char_kind, char_out, new_header});
        if (tag_fifo.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status=%0d kind=%0d char=%02h new=%0b",
                   $time, status, char_kind, char_out, new_header);
        end else begin
          want = tag_fifo.pop_front();
          if (got !== want) begin
            errors++;
            // fields shown as status/kind/char/new header
            $display("%0t: mismatch expected %0d/%0d/%02h/%0b got %0d/%0d/%02h/%0b",
                     $time, want.status, want.kind, want.ch, want.newh,
                     status, char_kind, char_out, new_header);
          end
        end
      end
      nxt_stall = 1'b0;
      if (long_hold > 0) begin
        long_hold--;
        nxt_stall = 1'b1;
      end else if (!long_hold_done && results_seen >= HOLD_AT) begin
        // hold off long enough for the block to fill and stall its input
        long_hold_done = 1'b1;
        long_hold = LONG_HOLD - 1;
        nxt_stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (feed_q.size() >= CALM_TAIL && $urandom_range(0, 99) < recv_idle_pct) begin
        stall_left = $urandom_range(0, 15);
        nxt_stall = 1'b1;
      end
      if ($urandom_range(0, 127) == 0) recv_idle_pct = pick_idle_pct();
      out_stall <= nxt_stall;
    end
  end

  // Build the byte stream, run it and report
  initial begin : stimulus
    bit paused_once;
    paused_once = 1'b0;

    // request line with faults injected in the method, URI, protocol and version
    push_byte(8'h00);
    push_byte(8'hff);
    push_text("G");
    push_byte("(");
    push_byte(CH_SPACE);
    push_byte(CH_DEL);
    push_byte(8'hff);
    push_byte(CH_SPACE);
    push_text("X");
    push_text("RTSP/");
    push_text("2");
    push_text("1.0");
    // CR CR completes, LF moves on to the headers
    push_byte(CH_CR);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_text("A:  v");
    push_byte(CH_CR);
    push_byte(CH_CR);

    // random header lines with faults and odd line ends
    while (feed_q.size() < RAND_END) begin
      if (!paused_once && feed_q.size() >= PAUSE_AT) begin
        feed_q.insert(feed_q.size(), PAUSE_MARK);
        paused_once = 1'b1;
      end
      repeat ($urandom_range(1, 6)) push_byte(rand_token());
      if ($urandom_range(0, 7) == 0) push_byte(8'($urandom_range(0, 255)));
      push_byte(CH_COLON);
      repeat ($urandom_range(0, 3)) push_byte(CH_SPACE);
      repeat ($urandom_range(0, 8)) push_byte(value_byte());
      case ($urandom_range(0, 5))
        0: begin push_byte(CH_CR); push_byte(CH_LF); end
        1: push_byte(CH_LF);
        2: push_byte(CH_CR);
        3: begin push_byte(CH_CR); push_byte(CH_CR); end
        4: begin push_byte(CH_CR); push_byte(CH_LF); push_byte(CH_CR); push_byte(CH_LF); end
        default: begin push_byte(CH_LF); push_byte(CH_LF); end
      endcase
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
    end

    // reach the end of the head from any header phase, then poke it
    allow_eoh = 1'b1;
    push_byte(CH_COLON);
    push_byte(CH_CR);
    push_byte("(");
    push_byte(CH_CR);
    repeat (30) begin
      case ($urandom_range(0, 2))
        0: push_byte(CH_CR);
        1: push_byte(CH_LF);
        default: push_byte(8'($urandom_range(0, 255)));
      endcase
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (feed_q.size() != 0 || draining || in_valid) @(posedge clk);
    while (tag_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
